// ----- design/u2f_pkg.sv -----
// ----------------------------------------------------------------------------
// u2f_pkg
// Types, constants and the font table lookup shared by the UTF-8 to font
// code mapper.
// ----------------------------------------------------------------------------
package u2f_pkg;

    localparam int POINT_W        = 21;
    localparam int BYTE_W         = 8;
    localparam int CODE_W         = 8;
    localparam int TABLE_LEN      = 47;
    localparam int MAP_ENTRIES_DEF = 47;

    // Fallback font code after reset is the question mark.
    localparam logic [CODE_W-1:0] FALLBACK_RESET = 8'h3F;

    // Font codes are handed out in table order starting here.
    localparam logic [CODE_W-1:0] FONT_CODE_BASE = 8'h80;

    localparam logic [POINT_W-1:0] ASCII_LIMIT = 21'd128;

    // Lead byte classes.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Queue between the decoder and the lookup stage.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [15:0] FONT_POINT [TABLE_LEN] = '{
        16'h0627, 16'h0628, 16'h062A, 16'h062B, 16'h062C, 16'h062D, 16'h062E, 16'h062F,
        16'h0630, 16'h0631, 16'h0632, 16'h0633, 16'h0634, 16'h0635, 16'h0636, 16'h0637,
        16'h0638, 16'h0639, 16'h063A, 16'h0641, 16'h0642, 16'h0643, 16'h0644, 16'h0645,
        16'h0646, 16'h0647, 16'h0648, 16'h064A, 16'h0649, 16'h0621, 16'h0622, 16'h0623,
        16'h0624, 16'h0625, 16'h0626, 16'h064B, 16'h064C, 16'h064D, 16'h064E, 16'h064F,
        16'h0650, 16'h0651, 16'h0652, 16'h060C, 16'h061B, 16'h061F, 16'h0640
    };

    // One decoded character travelling from the decoder to the lookup stage.
    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic               bad_lead;
    } u2f_event_t;

    // Queue status seen by the decoder and the lookup stage.
    typedef struct packed {
        logic full;
        logic not_empty;
    } u2f_qstat_t;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } u2f_map_t;

    // Table points are all distinct, so at most one entry matches.
    function automatic u2f_map_t u2f_lookup(input logic [POINT_W-1:0] cp,
                                            input int unsigned entries);
        u2f_map_t res;
        res.hit  = 1'b0;
        res.code = '0;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            if (i < entries && cp == {5'b0, FONT_POINT[i]})
            begin
                res.hit  = 1'b1;
                res.code = res.code | (FONT_CODE_BASE + CODE_W'(i));
            end
        end
        return res;
    endfunction

endpackage

// ----- design/u2f_front.sv -----
// ----------------------------------------------------------------------------
// u2f_front
// UTF-8 decoder: accepts one byte per cycle unless the queue is full, gathers
// multi-byte sequences, queues each completed character or invalid lead byte.
// ----------------------------------------------------------------------------
module u2f_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [u2f_pkg::BYTE_W-1:0] in_byte,
    input  u2f_pkg::u2f_qstat_t      qstat,
    output logic                     push,
    output u2f_pkg::u2f_event_t      push_data
);
    import u2f_pkg::*;

    logic [1:0]         pending_reg, pending_next;
    logic [POINT_W-1:0] partial_reg, partial_next;
    logic               accept;
    logic [POINT_W-1:0] shifted;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign shifted  = {partial_reg[POINT_W-7:0], in_byte[5:0]};

    always_comb
    begin
        pending_next         = pending_reg;
        partial_next         = partial_reg;
        push                 = 1'b0;
        push_data.code_point = '0;
        push_data.bad_lead   = 1'b0;
        if (accept)
        begin
            if (pending_reg != 2'd0)
            begin
                // Continuation bytes are not checked; the low six bits go in.
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    push                 = 1'b1;
                    push_data.code_point = shifted;
                    partial_next         = '0;
                end
                else
                begin
                    partial_next = shifted;
                end
            end
            else
            begin
                priority if (in_byte == '0)
                begin
                    // End of string: nothing to show.
                end
                else if (!in_byte[7])
                begin
                    push                 = 1'b1;
                    push_data.code_point = POINT_W'(in_byte);
                end
                else if ((in_byte & LEAD2_MASK) == LEAD2_PAT)
                begin
                    partial_next = POINT_W'(in_byte[4:0]);
                    pending_next = 2'd1;
                end
                else if ((in_byte & LEAD3_MASK) == LEAD3_PAT)
                begin
                    partial_next = POINT_W'(in_byte[3:0]);
                    pending_next = 2'd2;
                end
                else if ((in_byte & LEAD4_MASK) == LEAD4_PAT)
                begin
                    partial_next = POINT_W'(in_byte[2:0]);
                    pending_next = 2'd3;
                end
                else
                begin
                    push               = 1'b1;
                    push_data.bad_lead = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            partial_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// ----- design/u2f_queue.sv -----
// ----------------------------------------------------------------------------
// u2f_queue
// Two-entry queue that lets the decoder and the lookup stage stall
// independently.
// ----------------------------------------------------------------------------
module u2f_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u2f_pkg::u2f_event_t push_data,
    input  logic                pop,
    output u2f_pkg::u2f_event_t head,
    output u2f_pkg::u2f_qstat_t qstat
);
    import u2f_pkg::*;

    u2f_event_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign head            = mem_reg[rd_ptr_reg];
    assign qstat.full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign qstat.not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/u2f_back.sv -----
// ----------------------------------------------------------------------------
// u2f_back
// Lookup stage: maps each queued character to its font code and holds the
// result in the output register until it is transferred.
// ----------------------------------------------------------------------------
module u2f_back #(
    parameter int MAP_ENTRIES = u2f_pkg::MAP_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [u2f_pkg::CODE_W-1:0] cfg_wr_data,
    input  u2f_pkg::u2f_event_t        head,
    input  u2f_pkg::u2f_qstat_t        qstat,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [u2f_pkg::CODE_W-1:0] font_code,
    output logic [u2f_pkg::POINT_W-1:0] code_point,
    output logic                       unmapped,
    output logic                       bad_lead
);
    import u2f_pkg::*;

    logic [CODE_W-1:0]  fallback_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  font_code_reg, font_code_next;
    logic [POINT_W-1:0] code_point_reg;
    logic               unmapped_reg, unmapped_next;
    logic               bad_lead_reg;
    u2f_map_t           map;

    // The output register refills whenever it is empty or being drained and the queue holds an entry.
    assign pop = qstat.not_empty && (!out_valid_reg || !out_stall);
    assign map = u2f_lookup(head.code_point, MAP_ENTRIES);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        font_code_next = '0;
        unmapped_next  = 1'b0;
        if (!head.bad_lead)
        begin
            if (head.code_point < ASCII_LIMIT)
            begin
                font_code_next = head.code_point[CODE_W-1:0];
            end
            else if (map.hit)
            begin
                font_code_next = map.code;
            end
            else
            begin
                font_code_next = fallback_reg;
                unmapped_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg  <= FALLBACK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fallback_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            font_code_reg  <= font_code_next;
            code_point_reg <= head.code_point;
            unmapped_reg   <= unmapped_next;
            bad_lead_reg   <= head.bad_lead;
        end
    end

    assign out_valid  = out_valid_reg;
    assign font_code  = font_code_reg;
    assign code_point = code_point_reg;
    assign unmapped   = unmapped_reg;
    assign bad_lead   = bad_lead_reg;

endmodule

// ----- design/utf8_to_font_code_mapper.sv -----
// ----------------------------------------------------------------------------
// utf8_to_font_code_mapper: UTF-8 byte stream to 8-bit font codes.
// A result passes through the queue entry and then the output register;
// one byte per cycle is accepted unless in_stall is raised by a full queue.
// Asynchronous active-low reset empties the queue and output, fallback = '?'.
// ----------------------------------------------------------------------------
module utf8_to_font_code_mapper #(
    parameter int MAP_ENTRIES = u2f_pkg::MAP_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [u2f_pkg::CODE_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u2f_pkg::BYTE_W-1:0]  in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u2f_pkg::CODE_W-1:0]  font_code,
    output logic [u2f_pkg::POINT_W-1:0] code_point,
    output logic                        unmapped,
    output logic                        bad_lead
);
    import u2f_pkg::*;

    logic       push;
    logic       pop;
    u2f_event_t push_data;
    u2f_event_t head;
    u2f_qstat_t qstat;

    u2f_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    u2f_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    u2f_back #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .font_code   (font_code),
        .code_point  (code_point),
        .unmapped    (unmapped),
        .bad_lead    (bad_lead)
    );

`ifndef SYNTHESIS
    // An invalid lead byte carries nothing else.
    a_bad_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_lead |-> font_code == '0 && code_point == '0 && !unmapped)
        else $error("bad lead result carries data");

    // The fallback is only used for code points outside ASCII.
    a_unmapped_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unmapped |-> code_point >= ASCII_LIMIT && !bad_lead)
        else $error("fallback used for an ASCII or bad lead result");

    // ASCII code points pass through unchanged.
    a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_lead && code_point < ASCII_LIMIT
        |-> font_code == code_point[CODE_W-1:0] && !unmapped)
        else $error("ASCII code point not passed through");

    // A new result loads only when the queue held one.
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(qstat.not_empty))
        else $error("output loaded from an empty queue");
`endif

endmodule
